// File: design/wspc_pkg.sv
// Shared types, constants and arithmetic helpers of the wall segment projection unit.
package wspc_pkg;

    // Projection constants
    localparam int FOCAL    = 1100;
    localparam int CENTRE_X = 960;
    localparam int CENTRE_Y = 520;

    // Lateral offset, depth and height widths after the view transform
    localparam int PX_W = 16;
    localparam int PY_W = 16;
    localparam int PZ_W = 19;

    // Register map, word index into the configuration space
    typedef enum logic [2:0] {
        REG_VIEWER_X  = 3'd0,
        REG_VIEWER_Y  = 3'd1,
        REG_VIEWER_Z  = 3'd2,
        REG_COS_VIEW  = 3'd3,
        REG_SIN_VIEW  = 3'd4,
        REG_LOOK_GAIN = 3'd5
    } reg_idx_t;

    // Viewer configuration
    typedef struct packed {
        logic        [11:0] vx;
        logic        [11:0] vy;
        logic signed [15:0] vz;
        logic signed [15:0] cosv;
        logic signed [15:0] sinv;
        logic signed [7:0]  gain;
    } cfg_t;

    // One transformed segment end in view space
    typedef struct packed {
        logic signed [PX_W-1:0] px;
        logic signed [PY_W-1:0] py;
        logic signed [PZ_W-1:0] pb;
        logic signed [PZ_W-1:0] pt;
    } end_t;

    // Divide by 16384, rounding toward zero
    function automatic logic signed [15:0] q14_trunc(input logic signed [29:0] s);
        logic signed [29:0] b;
        b = s + (s[29] ? 30'sd16383 : 30'sd0);
        return b[29:14];
    endfunction

    // Divide by 32, rounding toward zero
    function automatic logic signed [PZ_W-1:0] tilt_trunc(input logic signed [23:0] s);
        logic signed [23:0] b;
        b = s + (s[23] ? 24'sd31 : 24'sd0);
        return b[23:5];
    endfunction

    // Divide by 65536, rounding toward zero
    function automatic logic signed [PZ_W-1:0] clip_trunc(input logic signed [37:0] s);
        logic signed [37:0] b;
        b = s + (s[37] ? 38'sd65535 : 38'sd0);
        return b[34:16];
    endfunction

    // Saturate to the 24-bit screen range
    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        logic signed [23:0] r;
        priority if (v > 32'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -32'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// File: design/wall_segment_project_clip_unit.sv
// Top level of the wall segment projection and near plane clip unit.
//
//   channel  direction  handshake            contents
//   s_*      in         s_valid / s_ready    segment ends, heights, end swap
//   m_*      out        m_valid / m_ready    visible flag, screen columns and rows
//   apb      in/out     psel/penable/pready  viewer position, view angle, look gain
//
// One segment is accepted per cycle while s_ready is high. Each passes through the view
// transform, the clip (clip ratio divider, 4 bits a stage) and the perspective divide
// (six restoring dividers, 5 quotient bits a stage), in that order.
// Reset is synchronous, active low; it empties the pipeline and loads register defaults.
// A stall on m_ready holds the output register; upstream stages keep filling empty
// slots, so s_ready drops only once every stage holds a segment.
module wall_segment_project_clip_unit (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // segment input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [11:0]        s_end0_x,
    input  logic [11:0]        s_end0_y,
    input  logic [11:0]        s_end1_x,
    input  logic [11:0]        s_end1_y,
    input  logic signed [15:0] s_floor_z,
    input  logic signed [15:0] s_ceiling_z,
    input  logic               s_swap_ends,
    // projection result
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_visible,
    output logic signed [23:0] m_screen_x0,
    output logic signed [23:0] m_screen_x1,
    output logic signed [23:0] m_bottom_y0,
    output logic signed [23:0] m_bottom_y1,
    output logic signed [23:0] m_top_y0,
    output logic signed [23:0] m_top_y1
);
    import wspc_pkg::*;

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    logic               wr_en;
    logic               xf_valid;
    logic               xf_ready;
    end_t [1:0]         xf_ends;
    logic               cl_valid;
    logic               cl_ready;
    logic               cl_visible;
    end_t [1:0]         cl_ends;
    logic signed [23:0] res [6];

    // Register writes
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[4:2])
                REG_VIEWER_X:  cfg_next.vx   = pwdata[11:0];
                REG_VIEWER_Y:  cfg_next.vy   = pwdata[11:0];
                REG_VIEWER_Z:  cfg_next.vz   = pwdata[15:0];
                REG_COS_VIEW:  cfg_next.cosv = pwdata[15:0];
                REG_SIN_VIEW:  cfg_next.sinv = pwdata[15:0];
                REG_LOOK_GAIN: cfg_next.gain = pwdata[7:0];
                default:       cfg_next      = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.vx   <= 12'd0;
            cfg_reg.vy   <= 12'd0;
            cfg_reg.vz   <= 16'sd0;
            cfg_reg.cosv <= 16'sd16384;
            cfg_reg.sinv <= 16'sd0;
            cfg_reg.gain <= 8'sd1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Register reads
    always_comb begin
        unique case (paddr[4:2])
            REG_VIEWER_X:  prdata = {20'd0, cfg_reg.vx};
            REG_VIEWER_Y:  prdata = {20'd0, cfg_reg.vy};
            REG_VIEWER_Z:  prdata = 32'(cfg_reg.vz);
            REG_COS_VIEW:  prdata = 32'(cfg_reg.cosv);
            REG_SIN_VIEW:  prdata = 32'(cfg_reg.sinv);
            REG_LOOK_GAIN: prdata = 32'(cfg_reg.gain);
            default:       prdata = 32'd0;
        endcase
    end

    // View transform
    wspc_xform u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .end0_x    (s_end0_x),
        .end0_y    (s_end0_y),
        .end1_x    (s_end1_x),
        .end1_y    (s_end1_y),
        .floor_z   (s_floor_z),
        .ceiling_z (s_ceiling_z),
        .swap_ends (s_swap_ends),
        .out_valid (xf_valid),
        .out_ready (xf_ready),
        .out_ends  (xf_ends)
    );

    // Near plane clip
    wspc_clip u_clip (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (xf_valid),
        .in_ready    (xf_ready),
        .in_ends     (xf_ends),
        .out_valid   (cl_valid),
        .out_ready   (cl_ready),
        .out_visible (cl_visible),
        .out_ends    (cl_ends)
    );

    // Perspective divide and output register
    wspc_proj u_proj (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (cl_valid),
        .in_ready    (cl_ready),
        .in_visible  (cl_visible),
        .in_ends     (cl_ends),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_visible (m_visible),
        .res         (res)
    );

    assign m_screen_x0 = res[0];
    assign m_screen_x1 = res[1];
    assign m_bottom_y0 = res[2];
    assign m_bottom_y1 = res[3];
    assign m_top_y0    = res[4];
    assign m_top_y1    = res[5];

    // A free output slot always lets a new segment in
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled while output slot free");

    // Hidden segments carry all-zero screen fields
    a_hidden_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_visible) |-> (m_screen_x0 == 24'sd0 && m_screen_x1 == 24'sd0 &&
                                     m_bottom_y0 == 24'sd0 && m_bottom_y1 == 24'sd0 &&
                                     m_top_y0 == 24'sd0 && m_top_y1 == 24'sd0))
        else $error("hidden segment with nonzero screen fields");

endmodule

// File: design/wspc_xform.sv
// View transform pipeline: translate, rotate and apply the look tilt to both ends.
module wspc_xform (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wspc_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [11:0]          end0_x,
    input  logic [11:0]          end0_y,
    input  logic [11:0]          end1_x,
    input  logic [11:0]          end1_y,
    input  logic signed [15:0]   floor_z,
    input  logic signed [15:0]   ceiling_z,
    input  logic                 swap_ends,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wspc_pkg::end_t [1:0] out_ends
);
    import wspc_pkg::*;

    localparam int NS = 5;

    typedef struct {
        logic signed [12:0] dx [2];
        logic signed [12:0] dy [2];
        logic signed [16:0] hb;
        logic signed [16:0] ht;
        logic signed [28:0] xc [2];
        logic signed [28:0] ys [2];
        logic signed [28:0] yc [2];
        logic signed [28:0] xs [2];
        logic signed [15:0] px [2];
        logic signed [15:0] py [2];
        logic signed [23:0] gpy [2];
        end_t [1:0]         e;
    } xf_st_t;

    xf_st_t          st_reg  [NS];
    xf_st_t          st_next [NS];
    logic [NS-1:0]   v_reg;
    logic [NS:0]     ld;

    // Stage load enables, a stage moves when empty or when its successor moves
    always_comb begin
        ld[NS] = out_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            ld[s] = !v_reg[s] || ld[s+1];
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = v_reg[NS-1];
    assign out_ends  = st_reg[NS-1].e;

    // Stage logic
    always_comb begin
        logic [11:0] ex [2];
        logic [11:0] ey [2];
        ex[0] = swap_ends ? end1_x : end0_x;
        ey[0] = swap_ends ? end1_y : end0_y;
        ex[1] = swap_ends ? end0_x : end1_x;
        ey[1] = swap_ends ? end0_y : end1_y;
        st_next[0] = st_reg[0];
        for (int s = 1; s < NS; s++) begin
            st_next[s] = st_reg[s-1];
        end
        // translate by the viewer position
        for (int k = 0; k < 2; k++) begin
            st_next[0].dx[k] = $signed({1'b0, ex[k]}) - $signed({1'b0, cfg.vx});
            st_next[0].dy[k] = $signed({1'b0, ey[k]}) - $signed({1'b0, cfg.vy});
        end
        st_next[0].hb = 17'(floor_z) - 17'(cfg.vz);
        st_next[0].ht = 17'(ceiling_z) - 17'(cfg.vz);
        // rotation products
        for (int k = 0; k < 2; k++) begin
            st_next[1].xc[k] = st_reg[0].dx[k] * cfg.cosv;
            st_next[1].ys[k] = st_reg[0].dy[k] * cfg.sinv;
            st_next[1].yc[k] = st_reg[0].dy[k] * cfg.cosv;
            st_next[1].xs[k] = st_reg[0].dx[k] * cfg.sinv;
        end
        // rotation sums back to integer units
        for (int k = 0; k < 2; k++) begin
            st_next[2].px[k] = q14_trunc(30'(st_reg[1].xc[k]) - 30'(st_reg[1].ys[k]));
            st_next[2].py[k] = q14_trunc(30'(st_reg[1].yc[k]) + 30'(st_reg[1].xs[k]));
        end
        // tilt product
        for (int k = 0; k < 2; k++) begin
            st_next[3].gpy[k] = st_reg[2].py[k] * cfg.gain;
        end
        // tilted heights
        for (int k = 0; k < 2; k++) begin
            st_next[4].e[k].px = st_reg[3].px[k];
            st_next[4].e[k].py = st_reg[3].py[k];
            st_next[4].e[k].pb = tilt_trunc((24'(st_reg[3].hb) <<< 5) + st_reg[3].gpy[k]);
            st_next[4].e[k].pt = tilt_trunc((24'(st_reg[3].ht) <<< 5) + st_reg[3].gpy[k]);
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (ld[s]) begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        for (int s = 0; s < NS; s++) begin
            if (ld[s]) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

endmodule

// File: design/wspc_clip.sv
// Near plane clip: visibility, clip ratio divider and interpolation of the near end.
module wspc_clip (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wspc_pkg::end_t [1:0] in_ends,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_visible,
    output wspc_pkg::end_t [1:0] out_ends
);
    import wspc_pkg::*;

    localparam int NS        = 7;
    localparam int DIV_FIRST = 1;
    localparam int DIV_LAST  = 4;
    localparam int STEPS     = 4;

    typedef struct {
        end_t [1:0]         e;
        logic               vis;
        logic               clip;
        logic               near;
        logic [15:0]        d;
        logic [15:0]        rem;
        logic [15:0]        q;
        logic signed [16:0] dpx;
        logic signed [19:0] dpb;
        logic signed [19:0] dpt;
        logic signed [36:0] ppx;
        logic signed [36:0] ppb;
        logic signed [36:0] ppt;
    } cl_st_t;

    cl_st_t          st_reg  [NS];
    cl_st_t          st_next [NS];
    logic [NS-1:0]   v_reg;
    logic [NS:0]     ld;

    // Stage load enables
    always_comb begin
        ld[NS] = out_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            ld[s] = !v_reg[s] || ld[s+1];
        end
    end

    assign in_ready    = ld[0];
    assign out_valid   = v_reg[NS-1];
    assign out_visible = st_reg[NS-1].vis;
    assign out_ends    = st_reg[NS-1].e;

    // Stage logic
    always_comb begin
        end_t                   nr;
        end_t                   fr;
        end_t                   cn;
        logic                   pos0;
        logic                   pos1;
        logic                   nsel;
        logic [15:0]            r;
        logic signed [PZ_W-1:0] cpx;
        st_next[0] = st_reg[0];
        for (int s = 1; s < NS; s++) begin
            st_next[s] = st_reg[s-1];
        end

        // visibility, near end pick and clip setup
        pos0 = in_ends[0].py > 16'sd0;
        pos1 = in_ends[1].py > 16'sd0;
        nsel = !pos1;
        nr   = in_ends[nsel];
        fr   = in_ends[!nsel];
        st_next[0].e    = in_ends;
        st_next[0].vis  = pos0 || pos1;
        st_next[0].clip = (pos0 || pos1) && !(pos0 && pos1);
        st_next[0].near = nsel;
        st_next[0].d    = st_next[0].clip ? 16'(17'(fr.py) - 17'(nr.py)) : 16'd1;
        st_next[0].rem  = st_next[0].clip ? 16'(-nr.py) : 16'd0;
        st_next[0].q    = '0;
        st_next[0].dpx  = 17'(fr.px) - 17'(nr.px);
        st_next[0].dpb  = 20'(fr.pb) - 20'(nr.pb);
        st_next[0].dpt  = 20'(fr.pt) - 20'(nr.pt);

        // clip ratio, four quotient bits a stage (dividend below divisor)
        for (int s = DIV_FIRST; s <= DIV_LAST; s++) begin
            for (int j = 0; j < STEPS; j++) begin
                r = {st_next[s].rem[14:0], 1'b0};
                if (r >= st_next[s].d) begin
                    st_next[s].rem = r - st_next[s].d;
                    st_next[s].q   = {st_next[s].q[14:0], 1'b1};
                end else begin
                    st_next[s].rem = r;
                    st_next[s].q   = {st_next[s].q[14:0], 1'b0};
                end
            end
        end

        // ratio times the far minus near differences
        st_next[5].ppx = 37'($signed({1'b0, st_reg[4].q})) * 37'(st_reg[4].dpx);
        st_next[5].ppb = 37'($signed({1'b0, st_reg[4].q})) * 37'(st_reg[4].dpb);
        st_next[5].ppt = 37'($signed({1'b0, st_reg[4].q})) * 37'(st_reg[4].dpt);

        // interpolated near end, depth forced to one
        cn     = st_reg[5].e[st_reg[5].near];
        cpx    = clip_trunc((38'(cn.px) <<< 16) + 38'(st_reg[5].ppx));
        cn.pb  = clip_trunc((38'(cn.pb) <<< 16) + 38'(st_reg[5].ppb));
        cn.pt  = clip_trunc((38'(cn.pt) <<< 16) + 38'(st_reg[5].ppt));
        cn.px  = 16'(cpx);
        cn.py  = 16'sd1;
        if (st_reg[5].clip) begin
            st_next[6].e[st_reg[5].near] = cn;
        end
        // keep the divisor benign for hidden segments
        if (!st_reg[5].vis) begin
            st_next[6].e[0].py = 16'sd1;
            st_next[6].e[1].py = 16'sd1;
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (ld[s]) begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        for (int s = 0; s < NS; s++) begin
            if (ld[s]) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    // Both depths handed to the divider are positive
    a_depth_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_ends[0].py > 16'sd0 && out_ends[1].py > 16'sd0))
        else $error("clip output depth not positive");

endmodule

// File: design/wspc_proj.sv
// Perspective divide: six pipelined restoring dividers, centre offset and saturation.
module wspc_proj (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_visible,
    input  wspc_pkg::end_t [1:0] in_ends,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_visible,
    output logic signed [23:0]   res [6]
);
    import wspc_pkg::*;

    localparam int NS        = 9;
    localparam int LANES     = 6;
    localparam int DIV_FIRST = 2;
    localparam int DIV_LAST  = 7;
    localparam int STEPS     = 5;

    typedef struct {
        logic               vis;
        logic signed [29:0] num [LANES];
        logic               neg [LANES];
        logic [29:0]        nq  [LANES];
        logic [15:0]        rem [LANES];
        logic [15:0]        d   [2];
        logic signed [23:0] res [LANES];
    } pr_st_t;

    pr_st_t          st_reg  [NS];
    pr_st_t          st_next [NS];
    logic [NS-1:0]   v_reg;
    logic [NS:0]     ld;

    // Stage load enables, the last stage is the output register
    always_comb begin
        ld[NS] = out_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            ld[s] = !v_reg[s] || ld[s+1];
        end
    end

    assign in_ready    = ld[0];
    assign out_valid   = v_reg[NS-1];
    assign out_visible = st_reg[NS-1].vis;
    assign res         = st_reg[NS-1].res;

    // Lanes: x0, x1, bottom0, bottom1, top0, top1; end = lane mod 2
    always_comb begin
        logic signed [PZ_W-1:0] v;
        logic [15:0]            r;
        logic signed [31:0]     sq;
        st_next[0] = st_reg[0];
        for (int s = 1; s < NS; s++) begin
            st_next[s] = st_reg[s-1];
        end

        // numerator times focal length
        st_next[0].vis = in_visible;
        for (int k = 0; k < 2; k++) begin
            st_next[0].d[k] = in_ends[k].py;
        end
        for (int i = 0; i < LANES; i++) begin
            if (i < 2) begin
                v = PZ_W'(in_ends[i % 2].px);
            end else if (i < 4) begin
                v = in_ends[i % 2].pb;
            end else begin
                v = in_ends[i % 2].pt;
            end
            st_next[0].num[i] = 30'(v) * 30'(FOCAL);
        end

        // sign and magnitude
        for (int i = 0; i < LANES; i++) begin
            st_next[1].neg[i] = st_reg[0].num[i][29];
            st_next[1].nq[i]  = st_reg[0].num[i][29] ? 30'(-st_reg[0].num[i])
                                                     : 30'(st_reg[0].num[i]);
            st_next[1].rem[i] = '0;
        end

        // restoring division, five quotient bits a stage
        for (int s = DIV_FIRST; s <= DIV_LAST; s++) begin
            for (int i = 0; i < LANES; i++) begin
                for (int j = 0; j < STEPS; j++) begin
                    r = {st_next[s].rem[i][14:0], st_next[s].nq[i][29]};
                    st_next[s].nq[i] = {st_next[s].nq[i][28:0], 1'b0};
                    if (r >= st_next[s].d[i % 2]) begin
                        st_next[s].rem[i]   = r - st_next[s].d[i % 2];
                        st_next[s].nq[i][0] = 1'b1;
                    end else begin
                        st_next[s].rem[i] = r;
                    end
                end
            end
        end

        // restore sign, add centre, saturate; hidden segments give zero
        for (int i = 0; i < LANES; i++) begin
            sq = st_reg[7].neg[i] ? -$signed({2'b00, st_reg[7].nq[i]})
                                  : $signed({2'b00, st_reg[7].nq[i]});
            sq = sq + ((i < 2) ? 32'(CENTRE_X) : 32'(CENTRE_Y));
            st_next[8].res[i] = st_reg[7].vis ? sat24(sq) : 24'sd0;
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (ld[s]) begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        for (int s = 0; s < NS; s++) begin
            if (ld[s]) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

endmodule
